// ----- sv/hcr_pkg.sv -----
package hcr_pkg;

   // Line store geometry.
   localparam int MaxWidth = 2048;
   localparam int ColW     = $clog2(MaxWidth);

   // Field widths.
   localparam int FwW     = 12;
   localparam int KW      = 16;
   localparam int RespW   = 48;
   localparam int MomentW = 61;

   // Configuration register indexes.
   localparam logic CsrFrameWidth = 1'b0;
   localparam logic CsrCornerK    = 1'b1;

   // One classified pixel passed from the front to the back.
   typedef struct packed {
      logic [7:0]      gray;
      logic [ColW-1:0] col;
      logic            valid;
      logic            last;
   } hcr_item_type;

endpackage

// ----- sv/hcr_req_if.sv -----
interface hcr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;
   logic       frame_start;

   modport source (output valid, red, green, blue, frame_start, input ready);
   modport sink (input valid, red, green, blue, frame_start, output ready);
endinterface

// ----- sv/hcr_rsp_if.sv -----
interface hcr_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [47:0] response;
   logic               response_valid;
   logic               row_last;

   modport source (output valid, response, response_valid, row_last, input ready);
   modport sink (input valid, response, response_valid, row_last, output ready);
endinterface

// ----- sv/hcr_ram.sv -----
module hcr_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem_ff[raddr];
      end
   end

endmodule

// ----- sv/hcr_front.sv -----
module hcr_front import hcr_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   hcr_req_if.sink          req_ch,
   input  logic [FwW-1:0]   frame_width,
   input  logic             q_full,
   input  logic             clearing,
   output logic             push,
   output hcr_item_type     item
);

   logic [ColW-1:0] col_ff, col_in, col_cur;
   logic [2:0]      row_ff, row_in, row_cur;
   logic [FwW-1:0]  width_act;
   logic [15:0]     gray_sum;
   logic            last;

   assign req_ch.ready = !q_full && !clearing;
   assign push         = req_ch.valid && req_ch.ready;

   // Counters restart on the first pixel of a frame.
   assign col_cur = req_ch.frame_start ? '0 : col_ff;
   assign row_cur = req_ch.frame_start ? '0 : row_ff;

   // Width of zero acts as one, and widths beyond the line store are clamped.
   always_comb begin
      width_act = frame_width;
      if (frame_width == '0) begin
         width_act = FwW'(1);
      end else if (frame_width > FwW'(MaxWidth)) begin
         width_act = FwW'(MaxWidth);
      end
   end

   assign last = (FwW'(col_cur) + FwW'(1)) >= width_act;

   // Luma conversion with rounding.
   assign gray_sum = 16'd77 * 16'(req_ch.red) + 16'd150 * 16'(req_ch.green)
                   + 16'd29 * 16'(req_ch.blue) + 16'd128;

   assign item.gray  = gray_sum[15:8];
   assign item.col   = col_cur;
   assign item.valid = (col_cur >= ColW'(4)) && (row_cur >= 3'd4);
   assign item.last  = last;

   // Next column and saturating row count.
   always_comb begin
      col_in = col_cur + ColW'(1);
      row_in = row_cur;
      if (last) begin
         col_in = '0;
         if (row_cur < 3'd4) begin
            row_in = row_cur + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (push) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

endmodule

// ----- sv/hcr_queue.sv -----
module hcr_queue import hcr_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  hcr_item_type push_item,
   input  logic         pop,
   output hcr_item_type pop_item,
   output logic         full,
   output logic         empty
);

   hcr_item_type slot_ff [2];
   logic         wptr_ff, rptr_ff;
   logic [1:0]   count_ff;

   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign pop_item = slot_ff[rptr_ff];

   // Two-entry circular queue.
   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= 1'b0;
         rptr_ff  <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         if (push) begin
            wptr_ff <= !wptr_ff;
         end
         if (pop) begin
            rptr_ff <= !rptr_ff;
         end
         count_ff <= count_ff + 2'(push) - 2'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wptr_ff] <= push_item;
      end
   end

endmodule

// ----- sv/hcr_back.sv -----
module hcr_back import hcr_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           q_empty,
   input  hcr_item_type   q_item,
   output logic           pop,
   input  logic [KW-1:0]  corner_k,
   output logic           clearing,
   hcr_rsp_if.source      rsp_ch
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_READ, ST_GRAY, ST_GRAD, ST_MUL, ST_MWIN, ST_SUM, ST_PROD, ST_KT, ST_OUT
   } state_type;

   state_type            state_ff;
   hcr_item_type         item_ff;
   logic [ColW:0]        clr_ff;
   logic [7:0]           gw_ff [3][3];
   logic [MomentW-1:0]   mw_ff [3][3];
   logic [MomentW-1:0]   mold_ff, mnew_ff;
   logic signed [10:0]   gx_ff, gy_ff;
   logic [19:0]          ixx_ff, iyy_ff;
   logic signed [20:0]   ixy_ff;
   logic [23:0]          sxx_ff, syy_ff;
   logic signed [24:0]   sxy_ff;
   logic [47:0]          pxy_ff, pxx_ff;
   logic [49:0]          t2_ff, kt_ff;
   logic signed [48:0]   det_ff;
   logic                 out_valid_ff;
   logic signed [RespW-1:0] out_resp_ff;
   logic                 out_rvalid_ff, out_last_ff;

   logic [15:0]          gl;
   logic [MomentW-1:0]   mold, mnew, packed_new;
   logic [9:0]           gx_p, gx_n, gy_p, gy_n;
   logic signed [10:0]   gx_in, gy_in;
   logic signed [21:0]   pxx, pyy, pxy;
   logic [23:0]          sxx_in, syy_in;
   logic signed [24:0]   sxy_in;
   logic [24:0]          tsum;
   logic signed [49:0]   sxy_sq;
   logic [49:0]          kt_hi;
   logic [31:0]          kt_lo;
   logic signed [51:0]   resp_full;
   logic signed [RespW-1:0] resp_sat;
   logic                 gwe, mwe;
   logic [ColW-1:0]      waddr;

   assign clearing = !clr_ff[ColW];
   assign pop      = (state_ff == ST_IDLE) && !q_empty && !clearing;

   // Line stores: two gray rows packed per column, two moment rows.
   assign gwe   = clearing || (state_ff == ST_GRAY);
   assign mwe   = clearing || (state_ff == ST_MWIN);
   assign waddr = clearing ? clr_ff[ColW-1:0] : item_ff.col;

   hcr_ram #(.WIDTH(16), .DEPTH(MaxWidth)) u_gray_ram (
      .clock(clock), .we(gwe), .waddr(waddr),
      .wdata(clearing ? 16'd0 : {gl[7:0], item_ff.gray}),
      .re(state_ff == ST_READ), .raddr(item_ff.col), .rdata(gl)
   );

   hcr_ram #(.WIDTH(MomentW), .DEPTH(MaxWidth)) u_mold_ram (
      .clock(clock), .we(mwe), .waddr(waddr),
      .wdata(clearing ? '0 : mnew_ff),
      .re(state_ff == ST_READ), .raddr(item_ff.col), .rdata(mold)
   );

   hcr_ram #(.WIDTH(MomentW), .DEPTH(MaxWidth)) u_mnew_ram (
      .clock(clock), .we(mwe), .waddr(waddr),
      .wdata(clearing ? '0 : packed_new),
      .re(state_ff == ST_READ), .raddr(item_ff.col), .rdata(mnew)
   );

   // Sobel gradients from the gray window.
   assign gx_p  = 10'(gw_ff[0][2]) + {1'b0, gw_ff[1][2], 1'b0} + 10'(gw_ff[2][2]);
   assign gx_n  = 10'(gw_ff[0][0]) + {1'b0, gw_ff[1][0], 1'b0} + 10'(gw_ff[2][0]);
   assign gy_p  = 10'(gw_ff[2][0]) + {1'b0, gw_ff[2][1], 1'b0} + 10'(gw_ff[2][2]);
   assign gy_n  = 10'(gw_ff[0][0]) + {1'b0, gw_ff[0][1], 1'b0} + 10'(gw_ff[0][2]);
   assign gx_in = $signed({1'b0, gx_p}) - $signed({1'b0, gx_n});
   assign gy_in = $signed({1'b0, gy_p}) - $signed({1'b0, gy_n});

   // Gradient products.
   assign pxx = gx_ff * gx_ff;
   assign pyy = gy_ff * gy_ff;
   assign pxy = gx_ff * gy_ff;

   assign packed_new = {ixy_ff, iyy_ff, ixx_ff};

   // Window sums of the three moments.
   always_comb begin
      sxx_in = '0;
      syy_in = '0;
      sxy_in = '0;
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            sxx_in = sxx_in + 24'(mw_ff[i][j][19:0]);
            syy_in = syy_in + 24'(mw_ff[i][j][39:20]);
            sxy_in = sxy_in + 25'($signed(mw_ff[i][j][60:40]));
         end
      end
   end

   assign tsum   = 25'(sxx_ff) + 25'(syy_ff);
   assign sxy_sq = sxy_ff * sxy_ff;

   // k times trace squared, rounded half up, split into high and low parts.
   assign kt_hi = t2_ff[49:16] * corner_k;
   assign kt_lo = t2_ff[15:0] * corner_k + 32'd32768;

   // Final subtraction with saturation to the result range.
   assign resp_full = 52'(det_ff) - $signed({2'b00, kt_ff});
   always_comb begin
      resp_sat = resp_full[RespW-1:0];
      if (resp_full[51] && !(&resp_full[50:RespW-1])) begin
         resp_sat = {1'b1, {(RespW-1){1'b0}}};
      end else if (!resp_full[51] && (|resp_full[50:RespW-1])) begin
         resp_sat = {1'b0, {(RespW-1){1'b1}}};
      end
   end

   assign rsp_ch.valid          = out_valid_ff;
   assign rsp_ch.response       = out_resp_ff;
   assign rsp_ch.response_valid = out_rvalid_ff;
   assign rsp_ch.row_last       = out_last_ff;

   // Sequencer carrying one item through the stores and arithmetic.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         clr_ff       <= '0;
         out_valid_ff <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               gw_ff[i][j] <= '0;
               mw_ff[i][j] <= '0;
            end
         end
      end else begin
         if (clearing) begin
            clr_ff <= clr_ff + (ColW+1)'(1);
         end
         // The result register empties when taken, unless a new result refills it.
         if (out_valid_ff && rsp_ch.ready && state_ff != ST_OUT) begin
            out_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (pop) begin
                  item_ff  <= q_item;
                  state_ff <= ST_READ;
               end
            end
            ST_READ: begin
               state_ff <= ST_GRAY;
            end
            ST_GRAY: begin
               for (int i = 0; i < 3; i++) begin
                  gw_ff[i][0] <= gw_ff[i][1];
                  gw_ff[i][1] <= gw_ff[i][2];
               end
               gw_ff[0][2] <= gl[15:8];
               gw_ff[1][2] <= gl[7:0];
               gw_ff[2][2] <= item_ff.gray;
               mold_ff     <= mold;
               mnew_ff     <= mnew;
               state_ff    <= ST_GRAD;
            end
            ST_GRAD: begin
               gx_ff    <= gx_in;
               gy_ff    <= gy_in;
               state_ff <= ST_MUL;
            end
            ST_MUL: begin
               ixx_ff   <= pxx[19:0];
               iyy_ff   <= pyy[19:0];
               ixy_ff   <= pxy[20:0];
               state_ff <= ST_MWIN;
            end
            ST_MWIN: begin
               for (int i = 0; i < 3; i++) begin
                  mw_ff[i][0] <= mw_ff[i][1];
                  mw_ff[i][1] <= mw_ff[i][2];
               end
               mw_ff[0][2] <= mold_ff;
               mw_ff[1][2] <= mnew_ff;
               mw_ff[2][2] <= packed_new;
               state_ff    <= ST_SUM;
            end
            ST_SUM: begin
               sxx_ff   <= sxx_in;
               syy_ff   <= syy_in;
               sxy_ff   <= sxy_in;
               state_ff <= ST_PROD;
            end
            ST_PROD: begin
               pxx_ff   <= sxx_ff * syy_ff;
               pxy_ff   <= sxy_sq[47:0];
               t2_ff    <= tsum * tsum;
               state_ff <= ST_KT;
            end
            ST_KT: begin
               det_ff   <= $signed({1'b0, pxx_ff}) - $signed({1'b0, pxy_ff});
               kt_ff    <= kt_hi + 50'(kt_lo[31:16]);
               state_ff <= ST_OUT;
            end
            ST_OUT: begin
               if (!out_valid_ff || rsp_ch.ready) begin
                  out_valid_ff  <= 1'b1;
                  out_resp_ff   <= item_ff.valid ? resp_sat : '0;
                  out_rvalid_ff <= item_ff.valid;
                  out_last_ff   <= item_ff.last;
                  state_ff      <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

// ----- sv/harris_corner_response.sv -----
// Harris corner response over a raster-order RGB pixel stream. Each pixel is
// turned into 8-bit gray, Sobel gradients and their products are formed, the
// products are summed over a 3x3 window, and one result per pixel gives
// det - k*trace^2 for the centre two rows and two columns back, saturated to
// 48 bits, with response_valid set once the full 5x5 support is in frame.
// After reset the line stores are cleared, during which no item is accepted.
// Each item then passes through the back-end sequencer in order (store read,
// window update, gradients, products, sums, determinant, k term, result), and
// no new item is taken until its result is registered; a two-entry queue
// lets the front take items while the back is busy, and the result register
// lets the back finish while a result waits. The user must write frame_width
// and corner_k through the csr port while the block is idle; no check enforces it.
module harris_corner_response import hcr_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   hcr_req_if.sink       req_ch,
   hcr_rsp_if.source     rsp_ch,
   input  logic          csr_we,
   input  logic          csr_index,
   input  logic [KW-1:0] csr_wdata
);

   logic [FwW-1:0] frame_width_ff;
   logic [KW-1:0]  corner_k_ff;
   logic           q_full, q_empty, q_push, q_pop, clearing;
   hcr_item_type   push_item, pop_item;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff <= FwW'(1536);
         corner_k_ff    <= KW'(2621);
      end else if (csr_we) begin
         case (csr_index)
            CsrFrameWidth: frame_width_ff <= csr_wdata[FwW-1:0];
            CsrCornerK:    corner_k_ff    <= csr_wdata;
            default:       corner_k_ff    <= corner_k_ff;
         endcase
      end
   end

   hcr_front u_front (
      .clock(clock), .reset(reset), .req_ch(req_ch), .frame_width(frame_width_ff),
      .q_full(q_full), .clearing(clearing), .push(q_push), .item(push_item)
   );

   hcr_queue u_queue (
      .clock(clock), .reset(reset), .push(q_push), .push_item(push_item),
      .pop(q_pop), .pop_item(pop_item), .full(q_full), .empty(q_empty)
   );

   hcr_back u_back (
      .clock(clock), .reset(reset), .q_empty(q_empty), .q_item(pop_item),
      .pop(q_pop), .corner_k(corner_k_ff), .clearing(clearing), .rsp_ch(rsp_ch)
   );

   // An invalid result always carries a zero response.
   assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.response_valid |-> rsp_ch.response == '0)
      else $error("invalid result with non-zero response");

   // No item is taken while the line stores are being cleared.
   assert property (@(posedge clock) disable iff (reset)
      clearing |-> !req_ch.ready)
      else $error("item accepted during clearing pass");

   // The queue is never written when full.
   assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("queue overflow");

endmodule
